>>> hdl/arpc_pkg.sv
// Shared types and constants for the ARP cache with aging.
`default_nettype none
package arpc_pkg;

  localparam logic [63:0] TTL_RESET  = 64'd60000000000;
  localparam int          SLOT_OUT_W = 5;

  localparam logic FUNC_UPDATE = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  typedef struct packed {
    logic        func;
    logic [31:0] ip_address;
    logic [47:0] hw_address;
    logic [63:0] now_time;
  } arpc_in_t;

  typedef struct packed {
    logic                  hit;
    logic [47:0]           hw_result;
    logic [SLOT_OUT_W-1:0] slot_used;
  } arpc_out_t;

  typedef struct packed {
    logic        found;
    logic        expired;
    logic        free_found;
    logic [47:0] mac;
  } arpc_tok_t;

  typedef struct packed {
    logic        en;
    logic [31:0] ip;
    logic [47:0] mac;
    logic [63:0] expiry;
  } arpc_wr_t;

endpackage
`default_nettype wire

>>> hdl/arpc_cell.sv
// One cache slot; inspects the passing search token and hands it to the next slot.
`default_nettype none
module arpc_cell import arpc_pkg::*; #(
  parameter int ENTRIES = 32,
  parameter int IDX = 0,
  localparam int IW = $clog2(ENTRIES)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          go_in,
  input  wire arpc_tok_t     tok_in,
  input  wire logic [IW-1:0] fslot_in,
  input  wire logic [IW-1:0] frslot_in,
  output logic               go_out,
  output arpc_tok_t          tok_out,
  output logic [IW-1:0]      fslot_out,
  output logic [IW-1:0]      frslot_out,
  input  wire logic          func,
  input  wire logic [31:0]   key,
  input  wire logic [63:0]   now,
  input  wire arpc_wr_t      wr,
  input  wire logic [IW-1:0] wr_slot
);

  logic          valid_r, valid_nxt;
  logic [31:0]   ip_r;
  logic [47:0]   mac_r;
  logic [63:0]   exp_r;
  logic          go_r;
  arpc_tok_t     tok_r, tok_nxt;
  logic [IW-1:0] fslot_r, fslot_nxt;
  logic [IW-1:0] frslot_r, frslot_nxt;
  logic          mine;
  logic          expired;
  logic          wr_hit;

  assign mine    = !tok_in.found && valid_r && (ip_r == key);
  assign expired = (exp_r != 64'd0) && (now >= exp_r);
  assign wr_hit  = wr.en && (wr_slot == IW'(IDX));

  always_comb begin
    tok_nxt    = tok_in;
    fslot_nxt  = fslot_in;
    frslot_nxt = frslot_in;
    valid_nxt  = valid_r;
    if (mine) begin
      tok_nxt.found = 1'b1;
      fslot_nxt     = IW'(IDX);
      if (func == FUNC_LOOKUP) begin
        tok_nxt.expired = expired;
        tok_nxt.mac     = expired ? 48'd0 : mac_r;
      end
    end
    if (!tok_in.free_found && !valid_r) begin
      tok_nxt.free_found = 1'b1;
      frslot_nxt         = IW'(IDX);
    end
    // drop a stale entry found by a lookup
    if (go_in && mine && (func == FUNC_LOOKUP) && expired) begin
      valid_nxt = 1'b0;
    end
    if (wr_hit) begin
      valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      go_r    <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      go_r    <= go_in;
    end
  end

  always_ff @(posedge clk) begin
    if (go_in) begin
      tok_r    <= tok_nxt;
      fslot_r  <= fslot_nxt;
      frslot_r <= frslot_nxt;
    end
    if (wr_hit) begin
      ip_r  <= wr.ip;
      mac_r <= wr.mac;
      exp_r <= wr.expiry;
    end
  end

  assign go_out     = go_r;
  assign tok_out    = tok_r;
  assign fslot_out  = fslot_r;
  assign frslot_out = frslot_r;

endmodule
`default_nettype wire

>>> hdl/arp_cache_with_aging.sv
// Top level of the ARP cache with aging: item control, chain of slots, write-back.
// Usage:
//   Input channel in_valid/in_stall/in_data carries one item: func selects learn
//   (update) or lookup, with an IPv4 key, a MAC to store and the current time.
//   Output channel out_valid/out_stall/out_data returns exactly one item per input.
//   cfg_wr_en/cfg_wr_data write the time-to-live register; write it only while idle.
// Search:
//   A search token walks the chain of ENTRIES slots, one slot per cycle, then the
//   finish state decides the slot, writes it back and loads the output register.
//   A new item is accepted only in the idle state, so the next item is taken
//   only once the finish state of the last one has handed its result to the
//   output register.
// Reset:
//   All slots become invalid, the eviction pointer returns to slot 0 and the
//   time-to-live returns to 60 s. No clearing pass is needed.
// Stall:
//   A result waits in the output register while out_stall is high. The next item
//   may be accepted and searched meanwhile; its write-back waits until the
//   output register is free.
`default_nettype none
module arp_cache_with_aging import arpc_pkg::*; #(
  parameter int ENTRIES = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire arpc_in_t    in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output arpc_out_t        out_data,
  input  wire logic        cfg_wr_en,
  input  wire logic [63:0] cfg_wr_data
);

  localparam int IW = $clog2(ENTRIES);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

  state_t        state_r, state_nxt;
  arpc_in_t      item_r;
  logic          go_r;
  logic [63:0]   ttl_r;
  logic [IW-1:0] ptr_r, ptr_nxt;
  logic          out_valid_r, out_valid_nxt;
  arpc_out_t     out_r, out_nxt;

  logic          go    [ENTRIES+1];
  arpc_tok_t     tok   [ENTRIES+1];
  logic [IW-1:0] fslot [ENTRIES+1];
  logic [IW-1:0] frslot[ENTRIES+1];

  arpc_wr_t      wr;
  logic [IW-1:0] wr_slot;
  logic          in_fire;
  logic          fin_fire;
  logic [64:0]   exp_sum;
  logic [SLOT_OUT_W+IW-1:0] slot_ext;
  logic [IW-1:0] res_slot;

  assign in_fire  = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign fin_fire = (state_r == ST_FIN) && (!out_valid_r || !out_stall);

  assign go[0]     = go_r;
  assign tok[0]    = '0;
  assign fslot[0]  = '0;
  assign frslot[0] = '0;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    arpc_cell #(
      .ENTRIES (ENTRIES),
      .IDX     (i)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .go_in      (go[i]),
      .tok_in     (tok[i]),
      .fslot_in   (fslot[i]),
      .frslot_in  (frslot[i]),
      .go_out     (go[i+1]),
      .tok_out    (tok[i+1]),
      .fslot_out  (fslot[i+1]),
      .frslot_out (frslot[i+1]),
      .func       (item_r.func),
      .key        (item_r.ip_address),
      .now        (item_r.now_time),
      .wr         (wr),
      .wr_slot    (wr_slot)
    );
  end

  assign exp_sum = {1'b0, item_r.now_time} + {1'b0, ttl_r};

  always_comb begin
    res_slot = '0;
    if (item_r.func == FUNC_UPDATE) begin
      priority if (tok[ENTRIES].found) begin
        res_slot = fslot[ENTRIES];
      end else if (tok[ENTRIES].free_found) begin
        res_slot = frslot[ENTRIES];
      end else begin
        res_slot = ptr_r;
      end
    end else if (tok[ENTRIES].found) begin
      res_slot = fslot[ENTRIES];
    end
  end

  assign slot_ext = {{SLOT_OUT_W{1'b0}}, res_slot};

  always_comb begin
    state_nxt     = state_r;
    ptr_nxt       = ptr_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    wr            = '0;
    wr_slot       = '0;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (go[ENTRIES]) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (fin_fire) begin
          state_nxt = ST_IDLE;
          out_valid_nxt = 1'b1;
          out_nxt.slot_used = slot_ext[SLOT_OUT_W-1:0];
          if (item_r.func == FUNC_UPDATE) begin
            out_nxt.hit       = 1'b0;
            out_nxt.hw_result = 48'd0;
            wr.en   = 1'b1;
            wr.ip   = item_r.ip_address;
            wr.mac  = item_r.hw_address;
            wr_slot = res_slot;
            priority if (item_r.now_time == 64'd0) begin
              wr.expiry = 64'd0;
            end else if (exp_sum[64]) begin
              wr.expiry = '1;
            end else begin
              wr.expiry = exp_sum[63:0];
            end
            // advance the round-robin pointer on eviction
            if (!tok[ENTRIES].found && !tok[ENTRIES].free_found) begin
              ptr_nxt = (ptr_r == IW'(ENTRIES - 1)) ? '0 : ptr_r + 1'b1;
            end
          end else begin
            out_nxt.hit       = tok[ENTRIES].found && !tok[ENTRIES].expired;
            out_nxt.hw_result = tok[ENTRIES].found ? tok[ENTRIES].mac : 48'd0;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      go_r        <= 1'b0;
      ptr_r       <= '0;
      ttl_r       <= TTL_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      go_r        <= in_fire;
      ptr_r       <= ptr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        ttl_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r <= in_data;
    end
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire
